// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks in the decimal text formatter
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DTF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtf assertion failed");

// next-cycle implication
`define DTF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtf assertion failed");

`endif

// ===== rtl/dtf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtf_pkg
// constants and controller/datapath interface types of the formatter
// ---------------------------------------------------------------------------
package dtf_pkg;

   localparam logic [63:0] LOW_LIMIT     = 64'h3C9CD2B297D889BC;
   localparam logic [63:0] HIGH_LIMIT    = 64'h43F0000000000000;
   localparam logic [34:0] POW5_15       = 35'd30517578125;
   localparam logic [10:0] EXP_UNIT      = 11'd1075;
   localparam logic [12:0] SHIFT_OFFSET  = 13'd1060;
   localparam logic [5:0]  MULT_STEPS    = 6'd34;
   localparam logic [5:0]  CONV_STEPS    = 6'd63;
   localparam logic [4:0]  ALIGN_CAP_EXP = 5'd14;
   localparam logic [3:0]  FRAC_TOP      = 4'd14;
   localparam logic [7:0]  CHAR_ZERO     = 8'h30;
   localparam logic [7:0]  CHAR_DOT      = 8'h2E;
   localparam logic [7:0]  CHAR_FLAG     = 8'h00;

   typedef struct packed {
      logic load;
      logic mult_step;
      logic norm_step;
      logic shift_load;
      logic conv_step;
      logic round;
      logic inc;
      logic find;
      logic emit;
   } dtf_cmd_type;

   typedef struct packed {
      logic in_flag;
      logic cnt_zero;
      logic norm_done;
      logic cur_last;
      logic out_busy;
   } dtf_stat_type;

endpackage

// ===== rtl/dtf_controller.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtf_controller
// sequencer that steps the formatter datapath through one value
// ---------------------------------------------------------------------------
module dtf_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 rsp_ready,
   input  dtf_pkg::dtf_stat_type stat,
   output logic                 req_ready,
   output dtf_pkg::dtf_cmd_type cmd
);
   import dtf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MULT, ST_NORM, ST_SHIFT, ST_CONV,
      ST_ROUND, ST_INC, ST_FIND, ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      // no transfer while reset is held
      req_ready = (state_ff == ST_IDLE) && !reset;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = stat.in_flag ? ST_EMIT : ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult_step = 1'b1;
            if (stat.cnt_zero) state_in = ST_NORM;
         end
         ST_NORM: begin
            if (stat.norm_done) state_in = ST_SHIFT;
            else cmd.norm_step = 1'b1;
         end
         ST_SHIFT: begin
            cmd.shift_load = 1'b1;
            state_in = ST_CONV;
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (stat.cnt_zero) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in = ST_INC;
         end
         ST_INC: begin
            cmd.inc = 1'b1;
            state_in = ST_FIND;
         end
         ST_FIND: begin
            cmd.find = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!stat.out_busy || rsp_ready) begin
               cmd.emit = 1'b1;
               if (stat.cur_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/dtf_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtf_datapath
// multiply, normalize, bcd conversion, decimal rounding and byte output
// ---------------------------------------------------------------------------
module dtf_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  dtf_pkg::dtf_cmd_type cmd,
   output dtf_pkg::dtf_stat_type stat,
   input  logic [63:0]          req_value_bits,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_char_code,
   output logic                 rsp_is_last,
   output logic                 rsp_needs_fallback
);
   import dtf_pkg::*;

   typedef enum logic [2:0] {PH_WHOLE, PH_DOT, PH_FRAC, PH_ZERO, PH_FLAG} phase_type;

   logic [10:0]       exp_ff, exp_in;
   logic [63:0]       whole_ff, whole_in;
   logic [52:0]       f_ff, f_in;
   logic [87:0]       acc_ff, acc_in;
   logic [34:0]       csh_ff, csh_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              rnd_ff, rnd_in, stk_ff, stk_in;
   logic [5:0]        r_ff, r_in;
   logic [63:0]       fsh_ff, fsh_in;
   logic [19:0][3:0]  bw_ff, bw_in;
   logic [15:0][3:0]  bf_ff, bf_in;
   phase_type         ph_ff, ph_in;
   logic [4:0]        idx_ff, idx_in;
   logic [3:0]        low_ff, low_in;
   logic              fz_ff, fz_in;
   logic              rv_ff, rv_in;
   logic [7:0]        rc_ff, rc_in;
   logic              rl_ff, rl_in, rf_ff, rf_in;

   // input decode
   logic [10:0] in_exp, lsh, rsh;
   logic [52:0] in_mant, in_fpart;
   logic [63:0] in_whole;
   logic        in_flag;

   always_comb begin
      in_exp  = req_value_bits[62:52];
      in_mant = {1'b1, req_value_bits[51:0]};
      in_flag = (req_value_bits < LOW_LIMIT) || (req_value_bits >= HIGH_LIMIT);
      lsh     = in_exp - EXP_UNIT;
      rsh     = EXP_UNIT - in_exp;
      if (in_exp >= EXP_UNIT) begin
         in_whole = {11'd0, in_mant} << lsh[5:0];
         in_fpart = '0;
      end else if (rsh >= 11'd64) begin
         in_whole = '0;
         in_fpart = in_mant;
      end else begin
         in_whole = {11'd0, in_mant} >> rsh[5:0];
         in_fpart = in_mant & ~({53{1'b1}} << rsh[5:0]);
      end
   end

   // round to 53 bits, then scale by the binary exponent
   logic [53:0] q;
   logic [63:0] q64, frac_val;
   logic [12:0] t_val, t_neg;

   always_comb begin
      q     = {1'b0, acc_ff[52:0]} + {53'd0, rnd_ff & (stk_ff | acc_ff[0])};
      q64   = {10'd0, q};
      t_val = {7'd0, r_ff} + {2'd0, exp_ff} - SHIFT_OFFSET;
      t_neg = 13'd0 - t_val;
      if (!t_val[12]) frac_val = (t_val >= 13'd64) ? '0 : (q64 << t_val[5:0]);
      else            frac_val = (t_neg >= 13'd64) ? '0 : (q64 >> t_neg[5:0]);
   end

   // double dabble adjust
   logic [19:0][3:0] wa;
   logic [15:0][3:0] fa;

   always_comb begin
      for (int j = 0; j < 20; j++)
         wa[j] = (bw_ff[j] >= 4'd5) ? bw_ff[j] + 4'd3 : bw_ff[j];
      for (int j = 0; j < 16; j++)
         fa[j] = (bf_ff[j] >= 4'd5) ? bf_ff[j] + 4'd3 : bf_ff[j];
   end

   // half-up rounding at the alignment digit
   logic [4:0]       wdig, kk;
   logic [3:0]       k4, rdig;
   logic             up, alln;
   logic [15:0]      f_nine;
   logic [15:0][3:0] f_rnd;

   always_comb begin
      wdig = '0;
      for (int j = 0; j < 20; j++)
         if (bw_ff[j] != 4'd0) wdig = 5'(j + 1);
      kk   = wdig + 5'd1;
      if (kk > ALIGN_CAP_EXP) kk = ALIGN_CAP_EXP;
      k4   = kk[3:0];
      rdig = bf_ff[k4 - 4'd1];
      up   = (rdig >= 4'd5);
      for (int j = 0; j < 16; j++) f_nine[j] = (bf_ff[j] == 4'd9);
      for (int j = 0; j < 16; j++) begin
         alln = 1'b1;
         for (int i = 0; i < 16; i++)
            if (i >= int'(k4) && i < j && !f_nine[i]) alln = 1'b0;
         if (j < int'(k4)) f_rnd[j] = 4'd0;
         else if (up && alln) f_rnd[j] = f_nine[j] ? 4'd0 : bf_ff[j] + 4'd1;
         else f_rnd[j] = bf_ff[j];
      end
   end

   // carry into the integer digits
   logic             cry, wall;
   logic [19:0][3:0] w_inc;

   always_comb begin
      cry = (bf_ff[15] != 4'd0);
      for (int j = 0; j < 20; j++) begin
         wall = 1'b1;
         for (int i = 0; i < 20; i++)
            if (i < j && bw_ff[i] != 4'd9) wall = 1'b0;
         if (wall) w_inc[j] = (bw_ff[j] == 4'd9) ? 4'd0 : bw_ff[j] + 4'd1;
         else      w_inc[j] = bw_ff[j];
      end
   end

   // text bounds
   logic [4:0] top;
   logic [3:0] zlow;
   logic       fzero;

   always_comb begin
      top   = '0;
      zlow  = '0;
      fzero = 1'b1;
      for (int j = 0; j < 20; j++)
         if (bw_ff[j] != 4'd0) top = 5'(j);
      for (int j = 14; j >= 0; j--)
         if (bf_ff[j] != 4'd0) begin
            zlow  = 4'(j);
            fzero = 1'b0;
         end
   end

   // current byte
   logic [7:0] cur_char;
   logic       cur_last;

   always_comb begin
      cur_last = 1'b0;
      case (ph_ff)
         PH_WHOLE: cur_char = CHAR_ZERO | {4'd0, bw_ff[idx_ff]};
         PH_DOT:   cur_char = CHAR_DOT;
         PH_FRAC: begin
            cur_char = CHAR_ZERO | {4'd0, bf_ff[idx_ff[3:0]]};
            cur_last = (idx_ff[3:0] == low_ff);
         end
         PH_ZERO: begin
            cur_char = CHAR_ZERO;
            cur_last = 1'b1;
         end
         PH_FLAG: begin
            cur_char = CHAR_FLAG;
            cur_last = 1'b1;
         end
         default: cur_char = CHAR_FLAG;
      endcase
   end

   always_comb begin
      exp_in = exp_ff;  whole_in = whole_ff;  f_in = f_ff;
      acc_in = acc_ff;  csh_in = csh_ff;      cnt_in = cnt_ff;
      rnd_in = rnd_ff;  stk_in = stk_ff;      r_in = r_ff;
      fsh_in = fsh_ff;  bw_in = bw_ff;        bf_in = bf_ff;
      ph_in = ph_ff;    idx_in = idx_ff;      low_in = low_ff;  fz_in = fz_ff;
      rv_in = rv_ff;    rc_in = rc_ff;        rl_in = rl_ff;    rf_in = rf_ff;

      if (cmd.load) begin
         exp_in   = in_exp;
         whole_in = in_whole;
         f_in     = in_fpart;
         acc_in   = '0;
         csh_in   = POW5_15;
         cnt_in   = MULT_STEPS;
         rnd_in   = 1'b0;
         stk_in   = 1'b0;
         r_in     = '0;
         ph_in    = in_flag ? PH_FLAG : PH_WHOLE;
      end
      if (cmd.mult_step) begin
         acc_in = (acc_ff << 1) + (csh_ff[34] ? {35'd0, f_ff} : 88'd0);
         csh_in = csh_ff << 1;
         cnt_in = cnt_ff - 6'd1;
      end
      if (cmd.norm_step) begin
         acc_in = acc_ff >> 1;
         rnd_in = acc_ff[0];
         stk_in = stk_ff | rnd_ff;
         r_in   = r_ff + 6'd1;
      end
      if (cmd.shift_load) begin
         fsh_in = frac_val;
         bw_in  = '0;
         bf_in  = '0;
         cnt_in = CONV_STEPS;
      end
      if (cmd.conv_step) begin
         {bw_in, whole_in} = {wa, whole_ff} << 1;
         {bf_in, fsh_in}   = {fa, fsh_ff} << 1;
         cnt_in = cnt_ff - 6'd1;
      end
      if (cmd.round) bf_in = f_rnd;
      if (cmd.inc && cry) begin
         bf_in = '0;
         bw_in = w_inc;
      end
      if (cmd.find) begin
         ph_in  = PH_WHOLE;
         idx_in = top;
         low_in = zlow;
         fz_in  = fzero;
      end
      if (cmd.emit) begin
         rv_in = 1'b1;
         rc_in = cur_char;
         rl_in = cur_last;
         rf_in = (ph_ff == PH_FLAG);
         case (ph_ff)
            PH_WHOLE: begin
               if (idx_ff == 5'd0) ph_in = PH_DOT;
               else idx_in = idx_ff - 5'd1;
            end
            PH_DOT: begin
               ph_in  = fz_ff ? PH_ZERO : PH_FRAC;
               idx_in = {1'b0, FRAC_TOP};
            end
            PH_FRAC: idx_in = idx_ff - 5'd1;
            default: ph_in = ph_ff;
         endcase
      end else if (rsp_ready) begin
         rv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= rv_in;
      end
      exp_ff <= exp_in;  whole_ff <= whole_in;  f_ff <= f_in;
      acc_ff <= acc_in;  csh_ff <= csh_in;      cnt_ff <= cnt_in;
      rnd_ff <= rnd_in;  stk_ff <= stk_in;      r_ff <= r_in;
      fsh_ff <= fsh_in;  bw_ff <= bw_in;        bf_ff <= bf_in;
      ph_ff <= ph_in;    idx_ff <= idx_in;      low_ff <= low_in;  fz_ff <= fz_in;
      rc_ff <= rc_in;    rl_ff <= rl_in;        rf_ff <= rf_in;
   end

   assign stat.in_flag   = in_flag;
   assign stat.cnt_zero  = (cnt_ff == 6'd0);
   assign stat.norm_done = (acc_ff[87:53] == '0);
   assign stat.cur_last  = cur_last;
   assign stat.out_busy  = rv_ff;

   assign rsp_valid          = rv_ff;
   assign rsp_char_code      = rc_ff;
   assign rsp_is_last        = rl_ff;
   assign rsp_needs_fallback = rf_ff;

endmodule

// ===== rtl/double_to_fixed_decimal_text_top.sv =====
`timescale 1ns / 1ps
// sequence: a value passes from its transfer through multiply, normalize, scale load,
//   double dabble, round, carry and bound steps before its first byte is emitted
// flagged values go straight from the transfer to emit, which registers their single byte
// throughput: one value in flight; the next is taken once its last byte is registered,
//   and each value's bytes are emitted one per cycle while the receiver takes them
// reset: synchronous, clears the sequencer and the output valid, no clearing pass
// ---------------------------------------------------------------------------
// double_to_fixed_decimal_text_top
// ieee double to fixed-notation decimal text, one ascii byte per transfer
// ---------------------------------------------------------------------------
module double_to_fixed_decimal_text_top (
   input  logic        clock,
   input  logic        reset,
   // value input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_value_bits,
   // text output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_char_code,
   output logic        rsp_is_last,
   output logic        rsp_needs_fallback
);
   import dtf_pkg::*;

   // command and status between sequencer and datapath
   dtf_cmd_type  cmd;
   dtf_stat_type stat;

   // sequencer: idle, multiply, normalize, scale, convert, round, carry, bound, emit
   dtf_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // datapath: holds the value, its bcd digits and the output register
   dtf_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_value_bits     (req_value_bits),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_char_code      (rsp_char_code),
      .rsp_is_last        (rsp_is_last),
      .rsp_needs_fallback (rsp_needs_fallback)
   );

endmodule

// ===== rtl/dtf_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtf_checker
// port-level checks on the decimal text formatter
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dtf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_char_code,
   input logic       rsp_is_last,
   input logic       rsp_needs_fallback
);

   // a waiting byte is not withdrawn
   `DTF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // flagged result is a single zero byte
   `DTF_ASSERT_IMP(a_flag_byte, clock, reset, rsp_valid && rsp_needs_fallback, rsp_is_last && (rsp_char_code == 8'h00))

   // text bytes are digits or the dot
   `DTF_ASSERT_IMP(a_text_byte, clock, reset, rsp_valid && !rsp_needs_fallback, ((rsp_char_code >= 8'h30) && (rsp_char_code <= 8'h39)) || (rsp_char_code == 8'h2E))

   // one value at a time
   `DTF_ASSERT_NXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)

   // reset empties the output
   `DTF_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind double_to_fixed_decimal_text_top dtf_checker u_checker (.*);

// ===== bench/double_to_fixed_decimal_text_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// double_to_fixed_decimal_text_top_tb
// self-checking bench for the double to fixed decimal text formatter: a
// predictor builds the expected ascii bytes of every value transfer, and each
// text byte transfer is checked against the oldest expected byte
// ---------------------------------------------------------------------------
module double_to_fixed_decimal_text_top_tb;
   import dtf_pkg::*;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
      logic       fallback;
   } text_byte_type;

   localparam logic [63:0] ONE_E15     = 64'd1000000000000000;
   localparam logic [63:0] ROUND_CAP   = 64'd100000000000000;
   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          RANDOM_ITEMS = 128;
   localparam int          QUIET_ITEMS  = 25;

   // scoreboard: predicts the text of each accepted value, checks the bytes
   class text_scoreboard;
      text_byte_type expected_bytes[$];
      int         errors;
      int         bytes_checked;
      int         flagged_values;

      // trunc(round_to_53_bits(f * 10^15) * 2^e), done as f * 5^15 * 2^(e+15)
      function automatic logic [63:0] scaled_fraction(logic [63:0] f, int e);
         logic [127:0] prod, rem, half;
         logic [63:0]  q;
         int           len, r, t, i;
         if (f == 0) return 64'd0;
         prod = 128'(f) * 128'(POW5_15);
         len = 0;
         for (i = 127; i >= 0; i--) begin
            if (prod[i]) begin
               len = i + 1;
               break;
            end
         end
         r = (len > 53) ? len - 53 : 0;
         q = prod[63:0];
         if (r > 0) begin
            rem  = prod & ((128'd1 << r) - 128'd1);
            half = 128'd1 << (r - 1);
            q = 64'(prod >> r);
            if (rem > half || (rem == half && q[0])) q++;
         end
         t = r + e + 15;
         if (t >= 0) return (t < 64) ? (q << t) : 64'd0;
         t = -t;
         return (t < 64) ? (q >> t) : 64'd0;
      endfunction

      function void push_char(byte c);
         text_byte_type b;
         b.code = c;
         b.last = 1'b0;
         b.fallback = 1'b0;
         expected_bytes.push_back(b);
      endfunction

      function void note_value(logic [63:0] bits);
         text_byte_type b;
         logic [63:0] mant, whole, fpart, frac, align, p;
         int          e, i;
         string       s;
         if (bits < LOW_LIMIT || bits >= HIGH_LIMIT) begin
            b.code = CHAR_FLAG;
            b.last = 1'b1;
            b.fallback = 1'b1;
            expected_bytes.push_back(b);
            flagged_values++;
            return;
         end
         e = int'(bits[62:52]) - 1075;
         mant = {11'd0, 1'b1, bits[51:0]};
         if (e >= 0) begin
            whole = (e < 12) ? (mant << e) : 64'd0;
            fpart = 0;
         end else if (-e >= 64) begin
            whole = 0;
            fpart = mant;
         end else begin
            whole = mant >> (-e);
            fpart = mant & ((64'd1 << (-e)) - 64'd1);
         end
         frac = scaled_fraction(fpart, e);
         if (frac > 0) begin
            // rounding unit grows with the digits of the integer part
            align = 10;
            p = 1;
            while (whole >= p && align < ROUND_CAP) begin
               p = p * 10;
               align = align * 10;
            end
            if ((frac % align) * 10 / align >= 5) frac = frac + align;
            frac = frac - frac % align;
            if (frac >= ONE_E15) begin
               frac = frac - ONE_E15;
               whole++;
            end
         end
         s = $sformatf("%0d", whole);
         for (i = 0; i < s.len(); i++) push_char(s[i]);
         push_char(CHAR_DOT);
         if (frac == 0) push_char(CHAR_ZERO);
         else begin
            s = $sformatf("%0d", frac);
            while (s.len() < 15) s = {"0", s};
            while (s[s.len() - 1] == "0") s = s.substr(0, s.len() - 2);
            for (i = 0; i < s.len(); i++) push_char(s[i]);
         end
         b = expected_bytes.pop_back();
         b.last = 1'b1;
         expected_bytes.push_back(b);
      endfunction

      function void check_byte(logic [7:0] code, logic last, logic fallback);
         text_byte_type want;
         bytes_checked++;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected byte code=%h last=%b fallback=%b",
                     $time, code, last, fallback);
            errors++;
            return;
         end
         want = expected_bytes.pop_front();
         if (code !== want.code) begin
            $display("%0t: char_code expected %h actual %h", $time, want.code, code);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: is_last expected %b actual %b", $time, want.last, last);
            errors++;
         end
         if (fallback !== want.fallback) begin
            $display("%0t: needs_fallback expected %b actual %b",
                     $time, want.fallback, fallback);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_value_bits;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_char_code;
   logic        rsp_is_last;
   logic        rsp_needs_fallback;

   text_scoreboard text_sb;
   bit  quiet;        // no idling on either side in the last part of the run
   bit  long_hold;    // asks the receiver for one long back-pressure stretch
   int  values_sent;
   int  cycle_count;

   double_to_fixed_decimal_text_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_value_bits     (req_value_bits),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_char_code      (rsp_char_code),
      .rsp_is_last        (rsp_is_last),
      .rsp_needs_fallback (rsp_needs_fallback)
   );

   // 12 ns clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // text byte transfers, sampled at the edge with pre-edge values
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         text_sb.check_byte(rsp_char_code, rsp_is_last, rsp_needs_fallback);
   end

   // receiver: random stall bursts, one long hold-off so the block backs up
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_ready <= 1'b0;
            repeat (600) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 12);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // offer one value and hold it until the transfer
   task automatic send_value(logic [63:0] bits);
      int n;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_value_bits <= bits;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      text_sb.note_value(bits);
      values_sent++;
      if (values_sent == 40) long_hold = 1'b1;
   endtask

   // random doubles, weighted toward the formatted range
   function automatic logic [63:0] random_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: v[63:52] = {1'b0, 11'($urandom_range(11'h3C9, 11'h43E))};
         5:             v[63:52] = {1'b0, 11'($urandom_range(11'h3F0, 11'h40F))};
         6: begin
            // mantissa close to all ones pushes rounding into the integer part
            v[63:52] = {1'b0, 11'($urandom_range(11'h3E0, 11'h42F))};
            v[51:0]  = 52'hFFFFFFFFFFFFF - 52'($urandom_range(0, 64));
         end
         7: begin
            // exact binary fractions and integers
            v[63:52] = {1'b0, 11'($urandom_range(11'h3F6, 11'h43E))};
            v[40:0]  = 41'd0;
         end
         default: ;     // anything, including negatives, nan and infinities
      endcase
      return v;
   endfunction

   initial begin
      logic [63:0] directed[$];
      text_sb = new();
      quiet = 1'b0;
      long_hold = 1'b0;
      values_sent = 0;
      cycle_count = 0;
      req_valid = 1'b0;
      req_value_bits = 64'd0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      directed = '{
         LOW_LIMIT - 64'd1,         // just below the smallest formatted value
         LOW_LIMIT,                 // smallest formatted value
         HIGH_LIMIT - 64'd1,        // largest value below 2^64
         HIGH_LIMIT,                // 2^64
         64'h0000000000000000,      // +0
         64'h8000000000000000,      // -0
         64'hBFF0000000000000,      // negative
         64'h0000000000000001,      // subnormal
         64'h7FF0000000000000,      // infinity
         64'h7FF8000000000000,      // nan
         64'hFFFFFFFFFFFFFFFF,      // all ones
         64'h3FF0000000000000,      // 1.0, zero fraction
         64'h3FE0000000000000,      // 0.5
         64'h3FB999999999999A,      // 0.1
         64'h3FEFFFFFFFFFFFFF,      // just below 1, carry into integer
         64'h4058FFFFFFFFFFFF,      // just below 100, fraction rounds to zero
         64'h405EDD2F1A9FBE77,      // 123.456
         64'h4340000000000000,      // 2^53
         64'h43E0000000000000,      // 2^63
         64'h3FF8000000000000,      // 1.5
         64'h3FA999999999999A,      // 0.05
         64'h3CB0000000000000,      // tiny fraction, many leading zeros
         64'h7FEFFFFFFFFFFFFF       // largest finite
      };
      foreach (directed[i]) send_value(directed[i]);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         send_value(random_value());
      end
      req_valid <= 1'b0;

      // drain, then allow for a late stray byte
      while (text_sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("covered %0d values (%0d flagged), %0d text bytes checked",
               values_sent, text_sb.flagged_values, text_sb.bytes_checked);
      $display("included directed edge values, long back-pressure and random idling");
      if (text_sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== double_to_fixed_decimal_text_top.f =====
+incdir+rtl
rtl/dtf_pkg.sv
rtl/dtf_controller.sv
rtl/dtf_datapath.sv
rtl/double_to_fixed_decimal_text_top.sv
rtl/dtf_checker.sv
bench/double_to_fixed_decimal_text_top_tb.sv
